>>> hw/rtl/vbcc_pkg.sv
// shared types, constants and microcode table of the voxel box corner classifier
`default_nettype none

package vbcc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD   = 3'd0,
    CFG_BOX_WIDTH   = 3'd1,
    CFG_BOX_HEIGHT  = 3'd2,
    CFG_GRID_WIDTH  = 3'd3,
    CFG_GRID_HEIGHT = 3'd4,
    CFG_GRID_LAYERS = 3'd5
  } cfg_idx_e;

  localparam logic [15:0] ThresholdRst  = 16'd819;
  localparam logic [14:0] BoxWidthRst   = 15'd358;
  localparam logic [14:0] BoxHeightRst  = 15'd896;
  localparam logic [6:0]  GridWidthRst  = 7'd64;
  localparam logic [6:0]  GridHeightRst = 7'd64;
  localparam logic [3:0]  GridLayersRst = 4'd8;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_LW     = 3'd1,
    ST_LWH    = 3'd2,
    ST_CORNER = 3'd3,
    ST_ADDR   = 3'd4,
    ST_MAC    = 3'd5,
    ST_CMP    = 3'd6,
    ST_FINISH = 3'd7
  } step_e;

  typedef enum logic [2:0] {
    COND_NEVER       = 3'd0,
    COND_NO_START    = 3'd1,
    COND_SKIP        = 3'd2,
    COND_VOX_MORE    = 3'd3,
    COND_CORNER_MORE = 3'd4,
    COND_OUT_BUSY    = 3'd5
  } cond_e;

  typedef struct packed {
    logic  lw_en;
    logic  lwh_en;
    logic  corner_ld;
    logic  rd_en;
    logic  mac_en;
    logic  cmp_en;
    logic  finish;
    cond_e cond;
    step_e jump;
    step_e next;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic corner_skip;
    logic vox_more;
    logic corner_more;
    logic out_busy;
  } stat_t;

  function automatic ctrl_t ucode(step_e s);
    ctrl_t c;
    c      = '0;
    c.cond = COND_NEVER;
    c.jump = ST_IDLE;
    c.next = ST_IDLE;
    unique case (s)
      ST_IDLE: begin
        c.cond = COND_NO_START;
        c.jump = ST_IDLE;
        c.next = ST_LW;
      end
      ST_LW: begin
        c.lw_en = 1'b1;
        c.next  = ST_LWH;
      end
      ST_LWH: begin
        c.lwh_en = 1'b1;
        c.next   = ST_CORNER;
      end
      ST_CORNER: begin
        c.corner_ld = 1'b1;
        c.cond      = COND_SKIP;
        c.jump      = ST_CMP;
        c.next      = ST_ADDR;
      end
      ST_ADDR: begin
        c.rd_en = 1'b1;
        c.next  = ST_MAC;
      end
      ST_MAC: begin
        c.mac_en = 1'b1;
        c.cond   = COND_VOX_MORE;
        c.jump   = ST_ADDR;
        c.next   = ST_CMP;
      end
      ST_CMP: begin
        c.cmp_en = 1'b1;
        c.cond   = COND_CORNER_MORE;
        c.jump   = ST_CORNER;
        c.next   = ST_FINISH;
      end
      ST_FINISH: begin
        c.finish = 1'b1;
        c.cond   = COND_OUT_BUSY;
        c.jump   = ST_FINISH;
        c.next   = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/vbcc_store.sv
// single-port voxel density memory with registered read
`default_nettype none

module vbcc_store #(
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [15:0]              wdata_i,
  output logic [15:0]              rdata_o
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/vbcc_sequencer.sv
// microcode step counter with conditional jumps
`default_nettype none

module vbcc_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  vbcc_pkg::stat_t stat_i,
  output vbcc_pkg::ctrl_t ctrl_o,
  output logic           idle_o
);
  import vbcc_pkg::*;

  step_e upc_q, upc_d;
  ctrl_t ctrl;
  logic  taken;

  always_comb begin
    ctrl   = ucode(upc_q);
    ctrl_o = ctrl;
    idle_o = (upc_q == ST_IDLE);
  end

  always_comb begin
    unique case (ctrl.cond)
      COND_NEVER:       taken = 1'b0;
      COND_NO_START:    taken = !stat_i.start;
      COND_SKIP:        taken = stat_i.corner_skip;
      COND_VOX_MORE:    taken = stat_i.vox_more;
      COND_CORNER_MORE: taken = stat_i.corner_more;
      COND_OUT_BUSY:    taken = stat_i.out_busy;
      default:          taken = 1'b0;
    endcase
    upc_d = taken ? ctrl.jump : ctrl.next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= ST_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/vbcc_datapath.sv
// address, weight, multiply-accumulate and compare datapath
`default_nettype none

module vbcc_datapath #(
  parameter int unsigned MAX_COLUMNS = 64,
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned MAX_LAYERS  = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  vbcc_pkg::ctrl_t       ctrl_i,
  input  logic                  start_i,
  input  logic signed [15:0]    query_x_i,
  input  logic signed [15:0]    query_y_i,
  input  logic signed [7:0]     query_layer_i,
  input  logic signed [15:0]    threshold_i,
  input  logic [14:0]           box_width_i,
  input  logic [14:0]           box_height_i,
  input  logic [6:0]            grid_width_i,
  input  logic [6:0]            grid_height_i,
  input  logic [3:0]            grid_layers_i,
  input  logic [15:0]           rdata_i,
  output logic [$clog2(MAX_COLUMNS*MAX_ROWS*MAX_LAYERS)-1:0] rd_addr_o,
  output vbcc_pkg::stat_t       stat_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [3:0]            corner_mask_o,
  output logic                  all_solid_o
);
  import vbcc_pkg::*;

  localparam int unsigned Depth  = MAX_COLUMNS * MAX_ROWS * MAX_LAYERS;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned ColW   = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned RowW   = $clog2(MAX_ROWS + 1);
  localparam int unsigned LyrW   = $clog2(MAX_LAYERS + 1);
  localparam int unsigned LayerW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

  logic [ColW-1:0] w_eff;
  logic [RowW-1:0] h_eff;
  logic [LyrW-1:0] l_eff;

  logic [15:0]        x_q, y_q;
  logic [LayerW-1:0]  layer_q;
  logic               layer_ok_q;
  logic [AddrW-1:0]   lw_q, lwh_q;
  logic [1:0]         k_q, j_q;
  logic [7:0]         c0_q, r0_q, fx_q, fy_q;
  logic               ok_q;
  logic [16:0]        weight_q;
  logic signed [33:0] acc_q;
  logic [3:0]         mask_q;
  logic               out_valid_q;
  logic [3:0]         out_mask_q;

  logic [16:0]        xs, ys, xr, yt, px, py;
  logic               in_x, in_y, corner_ok;
  logic [9:0]         cs_raw, rs_raw, wm1, hm1, cs, rs;
  logic [8:0]         wx, wy;
  logic [17:0]        wprod;
  logic signed [33:0] prod, thr_ext;
  logic               solid, layer_ok, out_busy;

  always_comb begin
    if (grid_width_i == 7'd0) begin
      w_eff = ColW'(1);
    end else if (10'(grid_width_i) > 10'(MAX_COLUMNS)) begin
      w_eff = ColW'(MAX_COLUMNS);
    end else begin
      w_eff = ColW'(grid_width_i);
    end
    if (grid_height_i == 7'd0) begin
      h_eff = RowW'(1);
    end else if (10'(grid_height_i) > 10'(MAX_ROWS)) begin
      h_eff = RowW'(MAX_ROWS);
    end else begin
      h_eff = RowW'(grid_height_i);
    end
    if (grid_layers_i == 4'd0) begin
      l_eff = LyrW'(1);
    end else if (10'(grid_layers_i) > 10'(MAX_LAYERS)) begin
      l_eff = LyrW'(MAX_LAYERS);
    end else begin
      l_eff = LyrW'(grid_layers_i);
    end
  end

  assign layer_ok = !query_layer_i[7] && (8'(query_layer_i[6:0]) < 8'(l_eff));

  // corner point and range check
  always_comb begin
    xs        = {x_q[15], x_q};
    ys        = {y_q[15], y_q};
    xr        = xs + {2'b00, box_width_i};
    yt        = ys + {2'b00, box_height_i};
    px        = k_q[0] ? xr : xs;
    py        = k_q[1] ? ys : yt;
    in_x      = !px[16] && ({1'b0, px} <= 18'({w_eff, 8'h00}));
    in_y      = !py[16] && ({1'b0, py} <= 18'({h_eff, 8'h00}));
    corner_ok = layer_ok_q && in_x && in_y;
  end

  // neighbor address and bilinear weight
  always_comb begin
    cs_raw    = 10'(c0_q) + 10'(j_q[0]);
    rs_raw    = 10'(r0_q) + 10'(j_q[1]);
    wm1       = 10'(w_eff) - 10'd1;
    hm1       = 10'(h_eff) - 10'd1;
    cs        = (cs_raw > wm1) ? wm1 : cs_raw;
    rs        = (rs_raw > hm1) ? hm1 : rs_raw;
    rd_addr_o = lwh_q + AddrW'(rs) * AddrW'(w_eff) + AddrW'(cs);
    wx        = j_q[0] ? {1'b0, fx_q} : (9'd256 - {1'b0, fx_q});
    wy        = j_q[1] ? {1'b0, fy_q} : (9'd256 - {1'b0, fy_q});
    wprod     = wx * wy;
  end

  assign prod    = $signed(rdata_i) * $signed({1'b0, weight_q});
  assign thr_ext = {{2{threshold_i[15]}}, threshold_i, 16'h0000};
  assign solid   = ok_q && (acc_q > thr_ext);
  assign out_busy = out_valid_q && !out_ready_i;

  always_comb begin
    stat_o.start       = start_i;
    stat_o.corner_skip = !corner_ok;
    stat_o.vox_more    = (j_q != 2'd3);
    stat_o.corner_more = (k_q != 2'd3);
    stat_o.out_busy    = out_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= 2'd0;
      j_q         <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (start_i) begin
        k_q <= 2'd0;
      end else if (ctrl_i.cmp_en) begin
        k_q <= k_q + 2'd1;
      end
      if (ctrl_i.corner_ld) begin
        j_q <= 2'd0;
      end else if (ctrl_i.mac_en) begin
        j_q <= j_q + 2'd1;
      end
      if (ctrl_i.finish && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q        <= query_x_i;
      y_q        <= query_y_i;
      layer_q    <= LayerW'(query_layer_i);
      layer_ok_q <= layer_ok;
    end
    if (ctrl_i.lw_en) begin
      lw_q <= AddrW'(layer_q) * AddrW'(w_eff);
    end
    if (ctrl_i.lwh_en) begin
      lwh_q <= lw_q * AddrW'(h_eff);
    end
    if (ctrl_i.corner_ld) begin
      c0_q  <= px[15:8];
      r0_q  <= py[15:8];
      fx_q  <= px[7:0];
      fy_q  <= py[7:0];
      ok_q  <= corner_ok;
      acc_q <= '0;
    end
    if (ctrl_i.rd_en) begin
      weight_q <= wprod[16:0];
    end
    if (ctrl_i.mac_en) begin
      acc_q <= acc_q + prod;
    end
    if (ctrl_i.cmp_en) begin
      mask_q[k_q] <= solid;
    end
    if (ctrl_i.finish && !out_busy) begin
      out_mask_q <= mask_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign corner_mask_o = out_mask_q;
  assign all_solid_o   = (out_mask_q == 4'hF);

endmodule

`default_nettype wire

>>> hw/rtl/voxel_box_corner_classifier_unit.sv
// top level: configuration registers, voxel store, microcode sequencer and datapath
//
// channel  direction  signals
// in       input      in_valid_i / in_ready_o, func, voxel_index, density, query_*
// out      output     out_valid_o / out_ready_i, corner_mask, all_solid
// cfg      input      cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i
//
// a voxel write yields no result
// a query holds the sequencer through the steps below, and its result is registered at the finish step
// (transfer and 2 setup steps, per corner a load, four read/multiply-accumulate pairs and a
// compare, then a finish step); a corner off the grid or layer skips its reads
// the result waits in an output register; the next query finishes only once it is taken
// reset clears control and loads the configuration defaults; the voxel store holds nothing valid until written
`default_nettype none

module voxel_box_corner_classifier_unit #(
  parameter int unsigned MAX_COLUMNS = 64,
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned MAX_LAYERS  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [14:0]                   voxel_index_i,
  input  logic signed [15:0]            density_i,
  input  logic signed [15:0]            query_x_i,
  input  logic signed [15:0]            query_y_i,
  input  logic signed [7:0]             query_layer_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [3:0]                    corner_mask_o,
  output logic                          all_solid_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [vbcc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [vbcc_pkg::CfgDataW-1:0] cfg_data_i
);
  import vbcc_pkg::*;

  localparam int unsigned Depth = MAX_COLUMNS * MAX_ROWS * MAX_LAYERS;
  localparam int unsigned AddrW = $clog2(Depth);

  logic [15:0] threshold_q;
  logic [14:0] box_width_q, box_height_q;
  logic [6:0]  grid_width_q, grid_height_q;
  logic [3:0]  grid_layers_q;

  ctrl_t            ctrl;
  stat_t            stat;
  logic             idle;
  logic             in_xfer, start, idx_ok, mem_we, mem_en;
  logic [AddrW-1:0] rd_addr, mem_addr;
  logic [15:0]      rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q   <= ThresholdRst;
      box_width_q   <= BoxWidthRst;
      box_height_q  <= BoxHeightRst;
      grid_width_q  <= GridWidthRst;
      grid_height_q <= GridHeightRst;
      grid_layers_q <= GridLayersRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD:   threshold_q   <= cfg_data_i;
        CFG_BOX_WIDTH:   box_width_q   <= cfg_data_i[14:0];
        CFG_BOX_HEIGHT:  box_height_q  <= cfg_data_i[14:0];
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i[6:0];
        CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i[6:0];
        CFG_GRID_LAYERS: grid_layers_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = idle;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign start      = in_xfer && (func_i == FuncQuery);
  assign idx_ok     = 32'(voxel_index_i) < 32'(Depth);
  assign mem_we     = in_xfer && (func_i == FuncWrite) && idx_ok;
  assign mem_en     = mem_we || ctrl.rd_en;
  assign mem_addr   = mem_we ? AddrW'(voxel_index_i) : rd_addr;

  vbcc_store #(
    .DEPTH (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (density_i),
    .rdata_o (rdata)
  );

  vbcc_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .idle_o (idle)
  );

  vbcc_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .MAX_LAYERS  (MAX_LAYERS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .start_i       (start),
    .query_x_i     (query_x_i),
    .query_y_i     (query_y_i),
    .query_layer_i (query_layer_i),
    .threshold_i   (threshold_q),
    .box_width_i   (box_width_q),
    .box_height_i  (box_height_q),
    .grid_width_i  (grid_width_q),
    .grid_height_i (grid_height_q),
    .grid_layers_i (grid_layers_q),
    .rdata_i       (rdata),
    .rd_addr_o     (rd_addr),
    .stat_o        (stat),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .corner_mask_o (corner_mask_o),
    .all_solid_o   (all_solid_o)
  );

  a_query_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !in_ready_o)
    else $error("query transfer did not start the sequencer");

  a_no_read_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && ctrl.rd_en))
    else $error("store written and read in the same cycle");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a query in progress");

  a_solid_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (all_solid_o == (corner_mask_o == 4'hF)))
    else $error("all_solid disagrees with corner mask");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench of the voxel box corner classifier: directed rows then random phases
`timescale 1ns / 100ps

module testbench;
  import vbcc_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int DrainCycles = 60;
  localparam int MaxCols = 64;
  localparam int MaxRows = 64;
  localparam int MaxLayers = 8;
  localparam int StoreDepth = MaxCols * MaxRows * MaxLayers;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare7 = 3'd7;

  typedef struct packed {
    logic [3:0] mask;
    logic       solid;
  } corner_exp_t;

  typedef struct packed {
    logic        func;
    logic [14:0] vi;
    logic [15:0] dens;
    logic [15:0] qx;
    logic [15:0] qy;
    logic [7:0]  ql;
    bit          fill;
    bit          typed;
    logic [3:0]  mask;
    logic        solid;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_func = 1'b0;
  logic [14:0]         in_vi = '0;
  logic signed [15:0]  in_dens = '0;
  logic signed [15:0]  in_qx = '0;
  logic signed [15:0]  in_qy = '0;
  logic signed [7:0]   in_ql = '0;
  logic                out_ready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  logic       in_ready;
  logic       out_valid;
  logic [3:0] corner_mask;
  logic       all_solid;
  logic       cfg_ready;

  // shadow of the block's registers and voxel store
  logic signed [15:0] thr_q = ThresholdRst;
  logic [14:0]        box_w = BoxWidthRst;
  logic [14:0]        box_h = BoxHeightRst;
  logic [6:0]         grid_w = GridWidthRst;
  logic [6:0]         grid_h = GridHeightRst;
  logic [3:0]         grid_l = GridLayersRst;
  logic signed [15:0] voxels [0:StoreDepth-1];
  bit                 voxel_written [0:StoreDepth-1];

  corner_exp_t corner_due [$];
  corner_exp_t due_head;
  int          errors = 0;
  int          items_sent = 0;
  bit          idle_on = 1'b1;
  int unsigned cycles = 0;

  voxel_box_corner_classifier_unit u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .func_i       (in_func),
    .voxel_index_i(in_vi),
    .density_i    (in_dens),
    .query_x_i    (in_qx),
    .query_y_i    (in_qy),
    .query_layer_i(in_ql),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .corner_mask_o(corner_mask),
    .all_solid_o  (all_solid),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int clamp_dim(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void grid_dims(output int w, output int h, output int l);
    w = clamp_dim(int'(grid_w), MaxCols);
    h = clamp_dim(int'(grid_h), MaxRows);
    l = clamp_dim(int'(grid_l), MaxLayers);
  endfunction

  function automatic int vox_addr(input int col, input int row, input int layer,
                                  input int w, input int h);
    int c;
    int r;
    c = (col > w - 1) ? w - 1 : col;
    r = (row > h - 1) ? h - 1 : row;
    return layer * w * h + r * w + c;
  endfunction

  // corner k: 0 top-left, 1 top-right, 2 bottom-left, 3 bottom-right
  function automatic void corner_point(input int k, input int x, input int y,
                                       output int px, output int py);
    int bwi;
    int bhi;
    bwi = box_w;
    bhi = box_h;
    px = (k == 1 || k == 3) ? x + bwi : x;
    py = (k < 2) ? y + bhi : y;
  endfunction

  // store addresses and fractions of one corner, 0 when the corner is off the grid
  function automatic bit corner_taps(input int px, input int py, input int layer,
                                     input int w, input int h,
                                     output logic [3:0][14:0] a, output int fx, output int fy);
    int c0;
    int r0;
    a  = '0;
    fx = 0;
    fy = 0;
    if (px < 0 || px > w * 256 || py < 0 || py > h * 256) return 1'b0;
    c0 = px >> 8;
    r0 = py >> 8;
    fx = px & 255;
    fy = py & 255;
    a[0] = 15'(vox_addr(c0, r0, layer, w, h));
    a[1] = 15'(vox_addr(c0 + 1, r0, layer, w, h));
    a[2] = 15'(vox_addr(c0, r0 + 1, layer, w, h));
    a[3] = 15'(vox_addr(c0 + 1, r0 + 1, layer, w, h));
    return 1'b1;
  endfunction

  function automatic corner_exp_t predict_corners(input logic signed [15:0] qx,
                                                  input logic signed [15:0] qy,
                                                  input logic signed [7:0] ql);
    corner_exp_t e;
    int w, h, l, z, xi, yi, px, py, fx, fy;
    logic [3:0][14:0] a;
    longint acc;
    longint lim;
    e.mask = '0;
    grid_dims(w, h, l);
    z = ql;
    xi = qx;
    yi = qy;
    lim = thr_q;
    lim = lim * 65536;
    if (z >= 0 && z < l) begin
      for (int k = 0; k < 4; k++) begin
        corner_point(k, xi, yi, px, py);
        if (corner_taps(px, py, z, w, h, a, fx, fy)) begin
          acc = longint'(voxels[a[0]]) * (256 - fx) * (256 - fy)
              + longint'(voxels[a[1]]) * fx * (256 - fy)
              + longint'(voxels[a[2]]) * (256 - fx) * fy
              + longint'(voxels[a[3]]) * fx * fy;
          if (acc > lim) e.mask[k] = 1'b1;
        end
      end
    end
    e.solid = (e.mask == 4'hF);
    return e;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 15);
    if (r < 9) return 0;
    if (r < 15) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // densities cluster around the threshold so that masks vary
  function automatic logic signed [15:0] rand_density();
    int v;
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    v = int'(thr_q) + int'($urandom_range(0, 2048)) - 1024;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic send_item(input logic f, input logic [14:0] vi, input logic signed [15:0] dens,
                           input logic signed [15:0] qx, input logic signed [15:0] qy,
                           input logic signed [7:0] ql, input bit typed,
                           input logic [3:0] tmask, input logic tsolid);
    corner_exp_t e;
    int n;
    n = pick_gap();
    if (idle_on && n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= f;
    in_vi    <= vi;
    in_dens  <= dens;
    in_qx    <= qx;
    in_qy    <= qy;
    in_ql    <= ql;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (f == FuncWrite) begin
      voxels[vi] = dens;
      voxel_written[vi] = 1'b1;
    end else begin
      e = predict_corners(qx, qy, ql);
      if (typed) begin
        e.mask  = tmask;
        e.solid = tsolid;
      end
      corner_due.push_back(e);
    end
  endtask

  task automatic send_write(input logic [14:0] vi, input logic signed [15:0] dens);
    send_item(FuncWrite, vi, dens, 16'($urandom), 16'($urandom), 8'($urandom),
              1'b0, 4'h0, 1'b0);
  endtask

  task automatic send_query(input logic signed [15:0] qx, input logic signed [15:0] qy,
                            input logic signed [7:0] ql, input bit typed,
                            input logic [3:0] tmask, input logic tsolid);
    send_item(FuncQuery, 15'($urandom), 16'($urandom), qx, qy, ql, typed, tmask, tsolid);
  endtask

  // write every voxel a query will read that holds nothing yet, or all of them with fill
  task automatic ready_taps(input logic signed [15:0] qx, input logic signed [15:0] qy,
                            input logic signed [7:0] ql, input bit fill,
                            input logic signed [15:0] fill_val);
    int w, h, l, z, xi, yi, px, py, fx, fy;
    logic [3:0][14:0] a;
    grid_dims(w, h, l);
    z = ql;
    xi = qx;
    yi = qy;
    if (z >= 0 && z < l) begin
      for (int k = 0; k < 4; k++) begin
        corner_point(k, xi, yi, px, py);
        if (corner_taps(px, py, z, w, h, a, fx, fy)) begin
          for (int j = 0; j < 4; j++) begin
            if (fill || !voxel_written[a[j]]) send_write(a[j], fill ? fill_val : rand_density());
          end
        end
      end
    end
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_THRESHOLD:   thr_q  = data;
      CFG_BOX_WIDTH:   box_w  = data[14:0];
      CFG_BOX_HEIGHT:  box_h  = data[14:0];
      CFG_GRID_WIDTH:  grid_w = data[6:0];
      CFG_GRID_HEIGHT: grid_h = data[6:0];
      CFG_GRID_LAYERS: grid_l = data[3:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] thr, input logic [15:0] bw,
                            input logic [15:0] bh, input logic [15:0] gw,
                            input logic [15:0] gh, input logic [15:0] gl, input bit spare);
    cfg_write(CFG_THRESHOLD, thr);
    cfg_write(CFG_BOX_WIDTH, bw);
    cfg_write(CFG_BOX_HEIGHT, bh);
    cfg_write(CFG_GRID_WIDTH, gw);
    cfg_write(CFG_GRID_HEIGHT, gh);
    cfg_write(CFG_GRID_LAYERS, gl);
    if (spare) begin
      cfg_write(CfgIdxSpare6, 16'hFFFF);
      cfg_write(CfgIdxSpare7, 16'h5A5A);
    end
    cfg_valid <= 1'b0;
  endtask

  // block idle: no result outstanding and any voxel write retired
  task automatic settle();
    in_valid <= 1'b0;
    while (corner_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic random_step();
    int w, h, l, xs, ys, xi, yi, bwi, bhi, r;
    logic signed [15:0] qx, qy;
    logic signed [7:0] ql;
    grid_dims(w, h, l);
    bwi = box_w;
    bhi = box_h;
    r = $urandom_range(0, 15);
    if (r < 2) begin
      if ($urandom_range(0, 1) == 0) send_write(15'($urandom), rand_density());
      else send_write(15'($urandom_range(0, l * w * h - 1)), rand_density());
    end else begin
      if (r == 2) begin
        qx = 16'($urandom);
        qy = 16'($urandom);
        ql = 8'($urandom);
      end else begin
        xs = ((w > 8) ? 8 : w) * 256;
        ys = ((h > 8) ? 8 : h) * 256;
        xi = int'($urandom_range(0, xs + 512)) - 256;
        yi = int'($urandom_range(0, ys + 512)) - 256;
        if ($urandom_range(0, 3) == 0) xi = w * 256 - bwi + int'($urandom_range(0, 64)) - 32;
        if ($urandom_range(0, 3) == 0) yi = h * 256 - bhi + int'($urandom_range(0, 64)) - 32;
        qx = xi[15:0];
        qy = yi[15:0];
        r = $urandom_range(0, 9);
        if (r < 8) ql = 8'($urandom_range(0, l - 1));
        else if (r == 8) ql = 8'(l);
        else ql = 8'($urandom);
      end
      ready_taps(qx, qy, ql, 1'b0, 16'sd0);
      send_query(qx, qy, ql, 1'b0, 4'h0, 1'b0);
    end
  endtask

  task automatic run_phase(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) random_step();
  endtask

  // directed rows, run under the reset configuration (64 x 64 x 8 grid)
  stim_row_t dir_rows [0:20] = '{
    '{FuncQuery, 15'd0, 16'h0000, 16'h0000, 16'h0000, 8'hFF, 1'b0, 1'b1, 4'h0, 1'b0},
    '{FuncQuery, 15'd0, 16'h0000, 16'h0000, 16'h0000, 8'h08, 1'b0, 1'b1, 4'h0, 1'b0},
    '{FuncQuery, 15'd0, 16'h0000, 16'h0000, 16'h0000, 8'h80, 1'b0, 1'b1, 4'h0, 1'b0},
    '{FuncQuery, 15'd0, 16'h0000, 16'h0000, 16'h0000, 8'h7F, 1'b0, 1'b1, 4'h0, 1'b0},
    '{FuncQuery, 15'd0, 16'h0000, 16'h8000, 16'h8000, 8'h00, 1'b0, 1'b1, 4'h0, 1'b0},
    '{FuncQuery, 15'd0, 16'h0000, 16'h7FFF, 16'h7FFF, 8'h03, 1'b0, 1'b1, 4'h0, 1'b0},
    '{FuncWrite, 15'h0000, 16'h8000, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 4'h0, 1'b0},
    '{FuncWrite, 15'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 4'h0, 1'b0},
    '{FuncQuery, 15'd0, 16'h7FFF, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b1, 4'hF, 1'b1},
    '{FuncQuery, 15'd0, 16'h8000, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b1, 4'h0, 1'b0},
    '{FuncQuery, 15'd0, 16'h0000, 16'h0080, 16'h0040, 8'h00, 1'b0, 1'b0, 4'h0, 1'b0},
    '{FuncQuery, 15'd0, 16'h7FFF, 16'h3E9A, 16'h3C80, 8'h07, 1'b1, 1'b1, 4'hF, 1'b1},
    '{FuncQuery, 15'd0, 16'h0000, 16'h3E9B, 16'h3C81, 8'h07, 1'b0, 1'b0, 4'h0, 1'b0},
    '{FuncQuery, 15'd0, 16'h0000, 16'hFFFF, 16'h0000, 8'h00, 1'b0, 1'b0, 4'h0, 1'b0},
    '{FuncQuery, 15'd0, 16'h0000, 16'h0100, 16'hFFFF, 8'h00, 1'b0, 1'b0, 4'h0, 1'b0},
    '{FuncQuery, 15'd0, 16'h0000, 16'h1234, 16'h0A5A, 8'h02, 1'b0, 1'b0, 4'h0, 1'b0},
    '{FuncWrite, 15'h5555, 16'h2AAA, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 4'h0, 1'b0},
    '{FuncWrite, 15'h2AAA, 16'hD555, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 4'h0, 1'b0},
    '{FuncQuery, 15'd0, 16'd819, 16'h0200, 16'h0200, 8'h01, 1'b1, 1'b1, 4'h0, 1'b0},
    '{FuncQuery, 15'd0, 16'd820, 16'h0200, 16'h0200, 8'h01, 1'b1, 1'b1, 4'hF, 1'b1},
    '{FuncQuery, 15'd0, 16'h0000, 16'h2000, 16'h2000, 8'h05, 1'b0, 1'b0, 4'h0, 1'b0}
  };

  initial begin : stimulus
    stim_row_t row;
    int rw, rh, rl;
    logic [15:0] rthr;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.func == FuncWrite) begin
        send_write(row.vi, row.dens);
      end else begin
        ready_taps(row.qx, row.qy, row.ql, row.fill, row.dens);
        send_query(row.qx, row.qy, row.ql, row.typed, row.mask, row.solid);
      end
    end

    settle();
    set_config(16'd819, 16'd358, 16'd896, 16'd4, 16'd4, 16'd2, 1'b0);
    idle_on = 1'b1;
    run_phase(150);

    settle();
    set_config(16'h8000, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 1'b0);
    idle_on = 1'b0;
    run_phase(100);

    settle();
    set_config(16'h7FFF, 16'hFFFF, 16'h7FFF, 16'd0, 16'd127, 16'd0, 1'b1);
    idle_on = 1'b1;
    run_phase(80);

    settle();
    set_config(16'h0000, 16'd128, 16'd200, 16'd64, 16'd64, 16'd15, 1'b0);
    run_phase(150);

    settle();
    set_config(16'hF000, 16'd300, 16'd50, 16'd100, 16'd2, 16'd9, 1'b0);
    run_phase(120);

    for (int p = 0; p < 5; p++) begin
      settle();
      rw = $urandom_range(1, 8);
      rh = $urandom_range(1, 8);
      rl = $urandom_range(1, 8);
      rthr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4096));
      set_config(rthr, 16'($urandom_range(0, rw * 256 + 128)),
                 16'($urandom_range(0, rh * 256 + 128)), 16'(rw), 16'(rh), 16'(rl), 1'b0);
      idle_on = ($urandom_range(0, 3) != 0);
      run_phase(80);
    end

    settle();
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin : out_pacer
    int n;
    @(posedge rst_n);
    forever begin
      n = pick_gap();
      if (idle_on && n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  // result transfer check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (corner_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: mask %h all_solid %b", corner_mask, all_solid);
      end else begin
        due_head = corner_due.pop_front();
        if (corner_mask !== due_head.mask || all_solid !== due_head.solid) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: mask %h (exp %h) all_solid %b (exp %b)",
                     corner_mask, due_head.mask, all_solid, due_head.solid);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

endmodule
